@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL.
// Concurrent checks, clocked and gated by an active-low reset.
// Synthesis builds see empty bodies.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/itrd_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itrd_pkg
// Types, constants and digit helpers for the radix digit converter.
// ---------------------------------------------------------------------------
package itrd_pkg;

  localparam int VALUE_BITS_DEF = 31;

  localparam int BASE_W  = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;

  // Quotient bits resolved per divider cycle
  localparam int DIV_STEPS = 8;

  localparam logic [BASE_W-1:0]  BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0]  BASE_MAX   = 6'd36;
  localparam logic [BASE_W-1:0]  BASE_RESET = 6'd10;
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA = 7'd65;
  localparam logic [CHAR_W-1:0]  CHAR_BAD   = 7'd63;

  // Divider status towards the sequencer
  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] rem;
  } div_status_t;

  // Digit stack commands
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  // Clamp a programmed radix into 2..36
  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    r = b;
    if (b < BASE_MIN) begin
      r = BASE_MIN;
    end else if (b > BASE_MAX) begin
      r = BASE_MAX;
    end
    return r;
  endfunction

  // Map a digit value onto its ASCII character
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [BASE_W-1:0]  base,
                                                       input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d >= base) begin
      c = CHAR_BAD;
    end else if (d < DEC_DIGITS) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_ALPHA + CHAR_W'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

@@ hdl/integer_to_radix_digits.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// integer_to_radix_digits
// Writes a non-negative integer out as ASCII digits in a radix of 2 to 36.
// ---------------------------------------------------------------------------
// One value enters on the in_ stream; its digits leave on the out_ stream as
// ASCII characters, most significant first, tlast on the final one. Zero
// gives the single character '0'. The radix comes from cfg_wr_data, written
// while the block is idle; values below 2 act as 2, above 36 act as 36.
// A value's radix is sampled when the value is taken.
// Each digit needs one pass of the shared divider, which resolves 8 quotient
// bits a cycle. The digits go onto a stack and are then sent at one a cycle
// while the receiver is ready; in_tready is high only between items. The
// first character is presented once every digit has been divided and stacked.
// When the receiver stalls the current character is held and sending waits.
// Reset sets the radix to 10 and empties the block.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_to_radix_digits #(
  parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration
  input  logic                          cfg_wr_en,
  input  logic [itrd_pkg::BASE_W-1:0]   cfg_wr_data,   // number_base
  // Input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0] in_tdata,    // number_in, zero pad
  // Output stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,     // digit_char[6:0], zero pad
  output logic                          out_tlast      // last_digit
);
  import itrd_pkg::*;

  localparam int DW = $clog2(VALUE_BITS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [BASE_W-1:0]   number_base_r, number_base_nxt;
  logic [BASE_W-1:0]   base_r, base_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic                out_tlast_r, out_tlast_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;

  logic                div_start;
  logic [BASE_W-1:0]   div_base;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_quotient;
  div_status_t         div_stat;

  stk_ctrl_t           stk_ctrl;
  logic [DIGIT_W-1:0]  stk_top;
  logic [DW-1:0]       stk_depth;

  itrd_divider #(.VALUE_BITS(VALUE_BITS)) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .base     (div_base),
    .dividend (div_dividend),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  itrd_digit_stack #(.DEPTH(VALUE_BITS)) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (stk_ctrl),
    .push_data (div_stat.rem),
    .top       (stk_top),
    .depth     (stk_depth)
  );

  // Sequence: divide until the quotient runs out, then pop digits out
  always_comb begin
    state_nxt       = state_r;
    base_nxt        = base_r;
    number_base_nxt = cfg_wr_en ? cfg_wr_data : number_base_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_tlast_nxt   = out_tlast_r;
    out_char_nxt    = out_char_r;
    div_start       = 1'b0;
    div_base        = base_r;
    div_dividend    = div_quotient;
    stk_ctrl        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          base_nxt     = clamp_base(number_base_r);
          div_base     = clamp_base(number_base_r);
          div_dividend = in_tdata[VALUE_BITS-1:0];
          div_start    = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          stk_ctrl.push = 1'b1;
          if ((div_quotient == '0) || (stk_depth == DW'(VALUE_BITS - 1))) begin
            state_nxt = S_EMIT;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_char_nxt   = digit_to_ascii(base_r, stk_top);
          out_tlast_nxt  = (stk_depth == DW'(1));
          out_tvalid_nxt = 1'b1;
          stk_ctrl.pop   = 1'b1;
          if (stk_depth == DW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      number_base_r <= BASE_RESET;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      number_base_r <= number_base_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
    base_r      <= base_nxt;
    out_tlast_r <= out_tlast_nxt;
    out_char_r  <= out_char_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_tlast_r;

  // Stack never underflows or overflows
  `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, stk_ctrl.pop, stk_depth != '0)
  `ASSERT_IMPLIES(a_push_notfull, clk, rst_n, stk_ctrl.push, stk_depth != DW'(VALUE_BITS))
  // Every remainder is a legal digit of the item radix
  `ASSERT_IMPLIES(a_rem_range, clk, rst_n, div_stat.done, div_stat.rem < base_r)
  // A new value starts with no digits left over
  `ASSERT_IMPLIES(a_empty_on_take, clk, rst_n, in_tvalid && in_tready, stk_depth == '0)
  // The final pop presents a character marked last
  `ASSERT_NEXT(a_last_flag, clk, rst_n, stk_ctrl.pop && (stk_depth == DW'(1)),
               out_tvalid && out_tlast)

endmodule

@@ hdl/itrd_divider.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itrd_divider
// Iterative restoring divider by a small radix, several quotient bits a cycle.
// ---------------------------------------------------------------------------
module itrd_divider #(
  parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [itrd_pkg::BASE_W-1:0] base,
  input  logic [VALUE_BITS-1:0]       dividend,
  output logic [VALUE_BITS-1:0]       quotient,
  output itrd_pkg::div_status_t       stat
);
  import itrd_pkg::*;

  localparam int DIV_CYCLES = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int PAD_W      = DIV_CYCLES * DIV_STEPS;
  localparam int CNT_W      = $clog2(DIV_CYCLES + 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [PAD_W-1:0]     quo_r, quo_nxt;
  logic [DIGIT_W-1:0]   rem_r, rem_nxt;
  logic [BASE_W-1:0]    base_r, base_nxt;
  logic [PAD_W-1:0]     quo_step;
  logic [DIGIT_W:0]     rem_step;

  // Shift dividend bits into the remainder, subtract the radix where it fits
  always_comb begin
    rem_step = {1'b0, rem_r};
    quo_step = quo_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem_step = {rem_step[DIGIT_W-1:0], quo_step[PAD_W-1]};
      quo_step = {quo_step[PAD_W-2:0], 1'b0};
      if (rem_step >= {1'b0, base_r}) begin
        rem_step    = rem_step - {1'b0, base_r};
        quo_step[0] = 1'b1;
      end
    end
  end

  // Load on start, then advance one group of bits a cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    base_nxt = base_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_CYCLES);
      quo_nxt  = PAD_W'(dividend);
      rem_nxt  = '0;
      base_nxt = base;
    end else if (busy_r) begin
      quo_nxt = quo_step;
      rem_nxt = rem_step[DIGIT_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    base_r <= base_nxt;
  end

  assign quotient  = quo_r[VALUE_BITS-1:0];
  assign stat.done = done_r;
  assign stat.rem  = rem_r;

endmodule

@@ hdl/itrd_digit_stack.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// itrd_digit_stack
// Last-in first-out store of digit values, top always at entry zero.
// ---------------------------------------------------------------------------
module itrd_digit_stack #(
  parameter int DEPTH = itrd_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  itrd_pkg::stk_ctrl_t          ctrl,
  input  logic [itrd_pkg::DIGIT_W-1:0] push_data,
  output logic [itrd_pkg::DIGIT_W-1:0] top,
  output logic [$clog2(DEPTH+1)-1:0]   depth
);
  import itrd_pkg::*;

  localparam int DW = $clog2(DEPTH + 1);

  logic [DIGIT_W-1:0] entry_r [DEPTH];
  logic [DW-1:0]      depth_r, depth_nxt;

  // Push shifts every entry down one place, pop shifts them back up
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (ctrl.push) begin
        entry_r[i] <= (i == 0) ? push_data : entry_r[(i == 0) ? 0 : i - 1];
      end else if (ctrl.pop && (i < DEPTH - 1)) begin
        entry_r[i] <= entry_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Track fill level
  always_comb begin
    depth_nxt = depth_r;
    if (ctrl.push) begin
      depth_nxt = depth_r + 1'b1;
    end else if (ctrl.pop) begin
      depth_nxt = depth_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  assign top   = entry_r[0];
  assign depth = depth_r;

endmodule
